// ----- src/lidar_point_camera_projection_core_macros.svh -----
// ----------------------------------------------------------------------------
// lidar point projection assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_PROJECTION_CORE_MACROS_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_CORE_MACROS_SVH

// condition must never hold
`define LPCP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define LPCP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/lpcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcp_pkg
// types, status codes and box limits of the lidar point projection core
// ----------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

	// input point beat
	typedef struct packed {
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               last_point;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [2:0]         status;
		logic [14:0]        pixel_u;
		logic [14:0]        pixel_v;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last_out;
	} out_item_t;

	// one projection row, c3 is the offset
	typedef struct packed {
		logic signed [31:0] c3;
		logic signed [31:0] c2;
		logic signed [31:0] c1;
		logic signed [31:0] c0;
	} row_t;

	typedef struct packed {
		row_t r2;
		row_t r1;
		row_t r0;
	} proj_t;

	// queue entry: point plus front classification
	typedef struct packed {
		in_item_t   pt;
		logic [2:0] cls;
	} q_item_t;

	// queue status toward front and checks
	typedef struct packed {
		logic empty;
		logic afull;
		logic full;
	} q_status_t;

	// status codes
	localparam logic [2:0] ST_KEPT   = 3'd0;
	localparam logic [2:0] ST_BOX    = 3'd1;
	localparam logic [2:0] ST_RANGE  = 3'd2;
	localparam logic [2:0] ST_BEHIND = 3'd3;
	localparam logic [2:0] ST_FRAME  = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_M00_M01 = 3'd0;
	localparam logic [2:0] CFG_M02_M03 = 3'd1;
	localparam logic [2:0] CFG_M10_M11 = 3'd2;
	localparam logic [2:0] CFG_M12_M13 = 3'd3;
	localparam logic [2:0] CFG_M20_M21 = 3'd4;
	localparam logic [2:0] CFG_M22_M23 = 3'd5;
	localparam logic [2:0] CFG_FRAME_W = 3'd6;
	localparam logic [2:0] CFG_FRAME_H = 3'd7;

	// box limits on raw q16.16
	localparam logic signed [31:0] BOX_X_MIN = 32'sd150732;
	localparam logic signed [31:0] BOX_Y_MAX = 32'sd327680;
	localparam logic signed [31:0] BOX_Y_MIN = -32'sd327680;
	localparam logic signed [31:0] BOX_Z_MIN = -32'sd98304;

	// 40 m squared in q32.32
	localparam logic [65:0] RANGE_LIMIT = 66'd1600 << 32;

	// queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

// ----- src/lpcp_front.sv -----
// ----------------------------------------------------------------------------
// lpcp_front
// accepts points, checks the front box and the range sphere
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  lpcp_pkg::in_item_t point,
	output logic              push,
	output lpcp_pkg::q_item_t entry
);
	import lpcp_pkg::*;

	logic        v_s1;
	in_item_t    pt_s1;
	logic        box_ok;
	logic [31:0] mx, my, mz;
	logic        v_s2;
	in_item_t    pt_s2;
	logic        box_s2;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;
	logic [65:0] sum;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_s1 <= point;
		end
	end

	// box test and magnitudes
	always_comb begin
		box_ok = (pt_s1.coord_x > BOX_X_MIN) && (pt_s1.coord_y > BOX_Y_MIN) &&
			(pt_s1.coord_y < BOX_Y_MAX) && (pt_s1.coord_z > BOX_Z_MIN);
		mx = pt_s1.coord_x[31] ? (~pt_s1.coord_x + 32'd1) : pt_s1.coord_x;
		my = pt_s1.coord_y[31] ? (~pt_s1.coord_y + 32'd1) : pt_s1.coord_y;
		mz = pt_s1.coord_z[31] ? (~pt_s1.coord_z + 32'd1) : pt_s1.coord_z;
	end

	// squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_s2  <= pt_s1;
		box_s2 <= box_ok;
		sqx_s2 <= 64'(mx) * 64'(mx);
		sqy_s2 <= 64'(my) * 64'(my);
		sqz_s2 <= 64'(mz) * 64'(mz);
	end

	// range test and classification
	always_comb begin
		sum = 66'(sqx_s2) + 66'(sqy_s2) + 66'(sqz_s2);
		entry.pt = pt_s2;
		priority if (!box_s2) begin
			entry.cls = ST_BOX;
		end else if (sum >= RANGE_LIMIT) begin
			entry.cls = ST_RANGE;
		end else begin
			entry.cls = ST_KEPT;
		end
		push = v_s2;
	end

endmodule

`default_nettype wire

// ----- src/lpcp_queue.sv -----
// ----------------------------------------------------------------------------
// lpcp_queue
// short fifo between the classifying front and the projecting back
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpcp_pkg::q_item_t  wr_item,
	input  logic               pop,
	output lpcp_pkg::q_item_t  rd_item,
	output lpcp_pkg::q_status_t stat
);
	import lpcp_pkg::*;

	q_item_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// head and status, front keeps two beats in flight
	always_comb begin
		rd_item    = mem_q[rd_ptr_q];
		stat.empty = (cnt_q == '0);
		stat.afull = (cnt_q >= QCW'(QDEPTH - 2));
		stat.full  = (cnt_q == QCW'(QDEPTH));
	end

endmodule

`default_nettype wire

// ----- src/lpcp_back.sv -----
// ----------------------------------------------------------------------------
// lpcp_back
// projection products, row sums, pipelined pixel division, frame test
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_back #(
	parameter int MAX_FRAME = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lpcp_pkg::q_item_t  in_item,
	input  lpcp_pkg::proj_t    proj,
	input  logic [11:0]        frame_width,
	input  logic [11:0]        frame_height,
	output logic               done,
	output lpcp_pkg::out_item_t result
);
	import lpcp_pkg::*;

	// quotient bits, divider width, frame limit width
	localparam int QB = $clog2(MAX_FRAME) + 4;
	localparam int DW = 68 + QB;
	localparam int LW = QB + 1;

	row_t               rows [3];
	logic               v_b1;
	q_item_t            it_b1;
	logic               v_b2;
	q_item_t            it_b2;
	logic signed [63:0] pr_b2 [3][3];
	logic signed [63:0] off_b2 [3];
	logic               v_b3;
	q_item_t            it_b3;
	logic signed [65:0] dot [3];
	logic signed [65:0] su_b3, sv_b3, ss_b3;
	logic [DW-1:0]      nu, nv, dsh;
	logic [2:0]         st0;

	// divider stage registers
	logic               dv_v_s  [QB+1];
	logic [2:0]         dv_st_s [QB+1];
	in_item_t           dv_pt_s [QB+1];
	logic [65:0]        dv_d_s  [QB+1];
	logic [DW-1:0]      dv_ru_s [QB+1];
	logic [DW-1:0]      dv_rv_s [QB+1];
	logic [QB-1:0]      dv_qu_s [QB+1];
	logic [QB-1:0]      dv_qv_s [QB+1];

	int unsigned        lim_w, lim_h;
	logic [LW-1:0]      wlim, hlim;
	logic [2:0]         st_fin;
	logic               done_q;
	out_item_t          result_q;

	assign rows[0] = proj.r0;
	assign rows[1] = proj.r1;
	assign rows[2] = proj.r2;

	// take the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		it_b1 <= in_item;
	end

	// coefficient products, one multiplier per term
	always_ff @(posedge clk) begin
		it_b2 <= it_b1;
		for (int r = 0; r < 3; r++) begin
			pr_b2[r][0] <= 64'(rows[r].c0) * 64'(it_b1.pt.coord_x);
			pr_b2[r][1] <= 64'(rows[r].c1) * 64'(it_b1.pt.coord_y);
			pr_b2[r][2] <= 64'(rows[r].c2) * 64'(it_b1.pt.coord_z);
			off_b2[r]   <= 64'(rows[r].c3) <<< 16;
		end
	end

	// row sums
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			dot[r] = 66'(pr_b2[r][0]) + 66'(pr_b2[r][1]) + 66'(pr_b2[r][2]) +
				66'(off_b2[r]);
		end
	end

	always_ff @(posedge clk) begin
		it_b3 <= it_b2;
		su_b3 <= dot[0];
		sv_b3 <= dot[1];
		ss_b3 <= dot[2];
	end

	// depth, sign and quotient overflow checks
	always_comb begin
		nu  = DW'({su_b3[63:0], 4'b0000});
		nv  = DW'({sv_b3[63:0], 4'b0000});
		dsh = DW'(ss_b3[65:0]) << QB;
		priority if (it_b3.cls != ST_KEPT) begin
			st0 = it_b3.cls;
		end else if (ss_b3 <= 66'sd0) begin
			st0 = ST_BEHIND;
		end else if (su_b3 < 66'sd0 || sv_b3 < 66'sd0) begin
			st0 = ST_FRAME;
		end else if (nu >= dsh || nv >= dsh) begin
			st0 = ST_FRAME;
		end else begin
			st0 = ST_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		dv_st_s[0] <= st0;
		dv_pt_s[0] <= it_b3.pt;
		dv_d_s[0]  <= ss_b3[65:0];
		dv_ru_s[0] <= nu;
		dv_rv_s[0] <= nv;
		dv_qu_s[0] <= '0;
		dv_qv_s[0] <= '0;
	end

	// restoring division, one quotient bit per stage, shared divisor
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [DW-1:0] sh;
		logic          gu, gv;

		always_comb begin
			sh = DW'(dv_d_s[k]) << B;
			gu = (dv_ru_s[k] >= sh);
			gv = (dv_rv_s[k] >= sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_st_s[k+1] <= dv_st_s[k];
			dv_pt_s[k+1] <= dv_pt_s[k];
			dv_d_s[k+1]  <= dv_d_s[k];
			dv_ru_s[k+1] <= gu ? (dv_ru_s[k] - sh) : dv_ru_s[k];
			dv_rv_s[k+1] <= gv ? (dv_rv_s[k] - sh) : dv_rv_s[k];
			dv_qu_s[k+1] <= dv_qu_s[k] | (QB'(gu) << B);
			dv_qv_s[k+1] <= dv_qv_s[k] | (QB'(gv) << B);
		end
	end

	// frame test against the clamped size
	always_comb begin
		lim_w = (32'(frame_width) > MAX_FRAME) ? MAX_FRAME : 32'(frame_width);
		lim_h = (32'(frame_height) > MAX_FRAME) ? MAX_FRAME : 32'(frame_height);
		wlim  = LW'(lim_w << 4);
		hlim  = LW'(lim_h << 4);
		if (dv_st_s[QB] == ST_KEPT &&
			(LW'(dv_qu_s[QB]) >= wlim || LW'(dv_qv_s[QB]) >= hlim)) begin
			st_fin = ST_FRAME;
		end else begin
			st_fin = dv_st_s[QB];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		result_q.status   <= st_fin;
		result_q.pixel_u  <= (st_fin == ST_KEPT) ? 15'(dv_qu_s[QB]) : 15'd0;
		result_q.pixel_v  <= (st_fin == ST_KEPT) ? 15'(dv_qv_s[QB]) : 15'd0;
		result_q.out_x    <= dv_pt_s[QB].coord_x;
		result_q.out_y    <= dv_pt_s[QB].coord_y;
		result_q.out_z    <= dv_pt_s[QB].coord_z;
		result_q.last_out <= dv_pt_s[QB].last_point;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- src/lidar_point_camera_projection_core.sv -----
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_core
// lidar point filter and pinhole projection to camera pixels
// ----------------------------------------------------------------------------
// One point is taken per clock while busy is low; each point gives exactly one
// result beat, strobed by done for a single cycle, in input order. The done
// strobe follows the accepting edge through the front, the queue and the back
// end; the pixel divider there resolves QB = log2(MAX_FRAME) + 4 quotient bits,
// one per pipeline stage. The receiver cannot stall and need
// not: the back end runs every cycle, so busy stays low in normal use.
// Write the projection and frame registers only while no point is in flight.
`default_nettype none

`include "lidar_point_camera_projection_core_macros.svh"

module lidar_point_camera_projection_core #(
	parameter int MAX_FRAME = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lpcp_pkg::in_item_t   point,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	output logic                 done,
	output lpcp_pkg::out_item_t  result
);
	import lpcp_pkg::*;

	proj_t       proj_q;
	logic [11:0] fw_q, fh_q;
	logic        accept;
	logic        push;
	q_item_t     entry;
	q_item_t     head;
	q_status_t   qstat;
	logic        pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q <= '0;
			fw_q   <= 12'd2048;
			fh_q   <= 12'd2048;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_M00_M01: begin
					proj_q.r0.c0 <= cfg_data[31:0];
					proj_q.r0.c1 <= cfg_data[63:32];
				end
				CFG_M02_M03: begin
					proj_q.r0.c2 <= cfg_data[31:0];
					proj_q.r0.c3 <= cfg_data[63:32];
				end
				CFG_M10_M11: begin
					proj_q.r1.c0 <= cfg_data[31:0];
					proj_q.r1.c1 <= cfg_data[63:32];
				end
				CFG_M12_M13: begin
					proj_q.r1.c2 <= cfg_data[31:0];
					proj_q.r1.c3 <= cfg_data[63:32];
				end
				CFG_M20_M21: begin
					proj_q.r2.c0 <= cfg_data[31:0];
					proj_q.r2.c1 <= cfg_data[63:32];
				end
				CFG_M22_M23: begin
					proj_q.r2.c2 <= cfg_data[31:0];
					proj_q.r2.c3 <= cfg_data[63:32];
				end
				CFG_FRAME_W: begin
					fw_q <= cfg_data[11:0];
				end
				CFG_FRAME_H: begin
					fh_q <= cfg_data[11:0];
				end
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign busy   = qstat.afull;
	assign accept = start && !busy;
	assign pop    = !qstat.empty;

	lpcp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.point  (point),
		.push   (push),
		.entry  (entry)
	);

	lpcp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (entry),
		.pop     (pop),
		.rd_item (head),
		.stat    (qstat)
	);

	lpcp_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pop),
		.in_item      (head),
		.proj         (proj_q),
		.frame_width  (fw_q),
		.frame_height (fh_q),
		.done         (done),
		.result       (result)
	);

	// checks
	`LPCP_ASSERT_NEVER(a_queue_overflow, push && qstat.full && !pop, "queue overflow")
	`LPCP_ASSERT_IMPLY(a_pixel_zero, done && (result.status != ST_KEPT),
		(result.pixel_u == 15'd0) && (result.pixel_v == 15'd0), "pixel set on reject")
	`LPCP_ASSERT_IMPLY(a_status_code, done, result.status <= ST_FRAME, "bad status code")

endmodule

`default_nettype wire
